>>> hdl/rst_pkg.sv
// ----------------------------------------------------------------------------
// rst_pkg
// Shared types, constants and the encoder function of the record slot table.
// ----------------------------------------------------------------------------
package rst_pkg;

	localparam int SLOTS  = 32;
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SLOT_W = 6;
	localparam int TIME_W = 32;
	localparam int DUR_W  = 16;
	localparam int WHAT_W = 16;
	localparam int CNT_W  = 6;
	localparam int STAT_W = 3;

	localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(SLOTS);

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_FREE   = 2'd1,
		KIND_SEEK   = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_EMPTY = 3'd2,
		ST_NONE  = 3'd3,
		ST_BAD   = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_LOAD = 1'b1
	} state_t;

	typedef struct packed {
		logic exec;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} enc_t;

	// Lowest set bit of the vector.
	function automatic enc_t first_set(input logic [SLOTS-1:0] vec);
		enc_t r;
		r.hit = 1'b0;
		r.idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (vec[i]) begin
				r.hit = 1'b1;
				r.idx = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

>>> hdl/rst_ctrl.sv
// ----------------------------------------------------------------------------
// rst_ctrl
// Controller: sequences one request through execute and result load, and
// tracks the response register.
// ----------------------------------------------------------------------------
module rst_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rst_pkg::cmd_t  cmd
);

	rst_pkg::state_t state_q, state_d;
	logic            full_q, full_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rst_pkg::S_IDLE;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			full_q  <= full_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.exec  = 1'b0;
		cmd.load  = 1'b0;
		req_ready = 1'b0;
		case (state_q)
			rst_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.exec = 1'b1;
					state_d  = rst_pkg::S_LOAD;
				end
			end
			rst_pkg::S_LOAD: begin
				if (!full_q || rsp_ready) begin
					cmd.load = 1'b1;
					state_d  = rst_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rst_pkg::S_IDLE;
			end
		endcase
		if (cmd.load) begin
			full_d = 1'b1;
		end else if (rsp_ready) begin
			full_d = 1'b0;
		end else begin
			full_d = full_q;
		end
	end

	assign rsp_valid = full_q;

endmodule

>>> hdl/rst_datapath.sv
// ----------------------------------------------------------------------------
// rst_datapath
// Occupancy vector with priority encoders, record memories, result stage and
// response register.
// ----------------------------------------------------------------------------
module rst_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rst_pkg::cmd_t                cmd,
	input  logic [1:0]                   kind,
	input  logic [4:0]                   slot,
	input  logic [rst_pkg::TIME_W-1:0]   rec_time,
	input  logic [rst_pkg::DUR_W-1:0]    rec_duration,
	input  logic [rst_pkg::WHAT_W-1:0]   rec_what,
	output logic [rst_pkg::STAT_W-1:0]   status,
	output logic [rst_pkg::SLOT_W-1:0]   found_slot,
	output logic [rst_pkg::TIME_W-1:0]   out_time,
	output logic [rst_pkg::DUR_W-1:0]    out_duration,
	output logic [rst_pkg::WHAT_W-1:0]   out_what,
	output logic [rst_pkg::CNT_W-1:0]    used_count
);

	logic [rst_pkg::TIME_W-1:0] time_mem [rst_pkg::SLOTS];
	logic [rst_pkg::DUR_W-1:0]  dur_mem  [rst_pkg::SLOTS];
	logic [rst_pkg::WHAT_W-1:0] what_mem [rst_pkg::SLOTS];

	logic [rst_pkg::SLOTS-1:0]  occ_q, occ_d;
	logic [rst_pkg::CNT_W-1:0]  count_q, count_d;

	logic [rst_pkg::TIME_W-1:0] rd_time_s1;
	logic [rst_pkg::DUR_W-1:0]  rd_dur_s1;
	logic [rst_pkg::WHAT_W-1:0] rd_what_s1;
	rst_pkg::status_t           status_s1, status_d;
	logic [rst_pkg::SLOT_W-1:0] found_s1, found_d;
	logic                       hit_s1, hit_d;

	logic [rst_pkg::STAT_W-1:0] status_q;
	logic [rst_pkg::SLOT_W-1:0] found_slot_q;
	logic [rst_pkg::TIME_W-1:0] out_time_q;
	logic [rst_pkg::DUR_W-1:0]  out_duration_q;
	logic [rst_pkg::WHAT_W-1:0] out_what_q;
	logic [rst_pkg::CNT_W-1:0]  used_count_q;

	logic [7:0]                 slot_ext;
	logic [rst_pkg::IDX_W-1:0]  idx;
	logic                       bad_idx;
	logic [rst_pkg::SLOTS-1:0]  ge_mask;
	rst_pkg::enc_t              free_enc, seek_enc;
	logic                       wr_en;

	assign slot_ext = 8'(slot);
	assign idx      = slot_ext[rst_pkg::IDX_W-1:0];
	assign bad_idx  = (int'(slot_ext) >= rst_pkg::SLOTS);

	always_comb begin
		for (int i = 0; i < rst_pkg::SLOTS; i++) begin
			ge_mask[i] = (i >= int'(slot_ext));
		end
	end

	assign free_enc = rst_pkg::first_set(~occ_q);
	assign seek_enc = rst_pkg::first_set(occ_q & ge_mask);

	always_comb begin
		status_d = rst_pkg::ST_BAD;
		found_d  = rst_pkg::NO_SLOT;
		hit_d    = 1'b0;
		wr_en    = 1'b0;
		occ_d    = occ_q;
		count_d  = count_q;
		case (rst_pkg::kind_t'(kind))
			rst_pkg::KIND_INSERT: begin
				if (rec_time == '0) begin
					status_d = rst_pkg::ST_BAD;
				end else if (!free_enc.hit) begin
					status_d = rst_pkg::ST_FULL;
				end else begin
					status_d             = rst_pkg::ST_OK;
					found_d              = rst_pkg::SLOT_W'(free_enc.idx);
					wr_en                = 1'b1;
					occ_d[free_enc.idx]  = 1'b1;
					count_d              = count_q + 1'b1;
				end
			end
			rst_pkg::KIND_FREE: begin
				if (bad_idx) begin
					status_d = rst_pkg::ST_BAD;
				end else if (!occ_q[idx]) begin
					status_d = rst_pkg::ST_EMPTY;
					found_d  = rst_pkg::SLOT_W'(idx);
				end else begin
					status_d   = rst_pkg::ST_OK;
					found_d    = rst_pkg::SLOT_W'(idx);
					occ_d[idx] = 1'b0;
					count_d    = count_q - 1'b1;
				end
			end
			rst_pkg::KIND_SEEK: begin
				if (bad_idx) begin
					status_d = rst_pkg::ST_BAD;
				end else if (!seek_enc.hit) begin
					status_d = rst_pkg::ST_NONE;
				end else begin
					status_d = rst_pkg::ST_OK;
					found_d  = rst_pkg::SLOT_W'(seek_enc.idx);
					hit_d    = 1'b1;
				end
			end
			default: begin
				status_d = rst_pkg::ST_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			occ_q   <= occ_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			time_mem[free_enc.idx] <= rec_time;
			dur_mem[free_enc.idx]  <= rec_duration;
			what_mem[free_enc.idx] <= rec_what;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_time_s1 <= time_mem[seek_enc.idx];
			rd_dur_s1  <= dur_mem[seek_enc.idx];
			rd_what_s1 <= what_mem[seek_enc.idx];
			status_s1  <= status_d;
			found_s1   <= found_d;
			hit_s1     <= hit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q       <= status_s1;
			found_slot_q   <= found_s1;
			used_count_q   <= count_q;
			out_time_q     <= hit_s1 ? rd_time_s1 : '0;
			out_duration_q <= hit_s1 ? rd_dur_s1 : '0;
			out_what_q     <= hit_s1 ? rd_what_s1 : '0;
		end
	end

	assign status       = status_q;
	assign found_slot   = found_slot_q;
	assign out_time     = out_time_q;
	assign out_duration = out_duration_q;
	assign out_what     = out_what_q;
	assign used_count   = used_count_q;

endmodule

>>> hdl/record_slot_table.sv
// ----------------------------------------------------------------------------
// record_slot_table
// Table of timestamped records with insert, free and seek requests.
// ----------------------------------------------------------------------------
// Channel  Handshake            Words
// req      req_valid/req_ready  kind, slot, rec_time, rec_duration, rec_what
// rsp      rsp_valid/rsp_ready  status, found_slot, out_time, out_duration,
//                               out_what, used_count
//
// The accept cycle runs the priority encoders over the occupancy vector and
// the memory access; the result loads once the response register is free or
// being taken. A new request is taken while a finished response waits; a
// third waits. Reset clears the occupancy vector and count at once; no sweep.
// ----------------------------------------------------------------------------
module record_slot_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [1:0]                   kind,
	input  logic [4:0]                   slot,
	input  logic [rst_pkg::TIME_W-1:0]   rec_time,
	input  logic [rst_pkg::DUR_W-1:0]    rec_duration,
	input  logic [rst_pkg::WHAT_W-1:0]   rec_what,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic [rst_pkg::STAT_W-1:0]   status,
	output logic [rst_pkg::SLOT_W-1:0]   found_slot,
	output logic [rst_pkg::TIME_W-1:0]   out_time,
	output logic [rst_pkg::DUR_W-1:0]    out_duration,
	output logic [rst_pkg::WHAT_W-1:0]   out_what,
	output logic [rst_pkg::CNT_W-1:0]    used_count
);

	rst_pkg::cmd_t cmd;

	rst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	rst_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.kind         (kind),
		.slot         (slot),
		.rec_time     (rec_time),
		.rec_duration (rec_duration),
		.rec_what     (rec_what),
		.status       (status),
		.found_slot   (found_slot),
		.out_time     (out_time),
		.out_duration (out_duration),
		.out_what     (out_what),
		.used_count   (used_count)
	);

endmodule

>>> hdl/rst_checker.sv
// ----------------------------------------------------------------------------
// rst_checker
// Port-level checks of the record slot table responses.
// ----------------------------------------------------------------------------
module rst_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [rst_pkg::STAT_W-1:0]   status,
	input logic [rst_pkg::SLOT_W-1:0]   found_slot,
	input logic [rst_pkg::TIME_W-1:0]   out_time,
	input logic [rst_pkg::DUR_W-1:0]    out_duration,
	input logic [rst_pkg::WHAT_W-1:0]   out_what,
	input logic [rst_pkg::CNT_W-1:0]    used_count
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(found_slot)
			&& $stable(out_time) && $stable(used_count))
		else $error("response changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> used_count <= rst_pkg::CNT_W'(rst_pkg::SLOTS))
		else $error("used count above table size");

	a_slot_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == rst_pkg::ST_FULL || status == rst_pkg::ST_NONE
			|| status == rst_pkg::ST_BAD) |-> found_slot == rst_pkg::NO_SLOT)
		else $error("failed request reports a slot");

	a_record_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != rst_pkg::ST_OK
			|-> out_time == '0 && out_duration == '0 && out_what == '0)
		else $error("record fields set on a failed request");

	a_ok_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == rst_pkg::ST_OK |-> found_slot < rst_pkg::NO_SLOT
			&& used_count != '0 || out_time == '0)
		else $error("successful request without a valid slot");

endmodule

bind record_slot_table rst_checker u_rst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp_valid),
	.rsp_ready    (rsp_ready),
	.status       (status),
	.found_slot   (found_slot),
	.out_time     (out_time),
	.out_duration (out_duration),
	.out_what     (out_what),
	.used_count   (used_count)
);
